/* rtl/flq_pkg.sv */
// flq_pkg: shared types and codes for the free-list linked queue
// holds command codes, result status codes, the controller state type and the item field widths
// no dependencies
`timescale 1ns / 1ps

package flq_pkg;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // widths of the item fields
  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;

endpackage

/* rtl/flq_in_if.sv */
// flq_in_if: command channel of the free-list linked queue
// carries valid, ready, the command code and the item to enqueue
// depends on flq_pkg
`timescale 1ns / 1ps

interface flq_in_if;
  import flq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

/* rtl/flq_out_if.sv */
// flq_out_if: result channel of the free-list linked queue
// carries valid, ready, the status, the dequeued item and the occupancy
// depends on flq_pkg
`timescale 1ns / 1ps

interface flq_out_if;
  import flq_pkg::*;

  logic                      valid;
  logic                      ready;
  status_t                   status;
  logic signed [VALUE_W-1:0] out_value;
  logic        [OCC_W-1:0]   occupancy;

  modport source (output valid, output status, output out_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input out_value, input occupancy,
                  output ready);
endinterface

/* rtl/free_list_linked_queue.sv */
// free_list_linked_queue: fifo kept as a linked list in a node pool with a free list
// result: registered in S_EXEC, which executes the command accepted in S_IDLE
// flow: a new command is accepted only in S_IDLE, after the link memory read at accept
//   and the write-back in S_EXEC; a result waiting at the output stalls the next
// reset: synchronous active low; queue empty, all nodes free, no clearing pass
//   (never-allocated nodes are tracked by a fill mark and read as a chain i to i+1)
`timescale 1ns / 1ps

module free_list_linked_queue #(
  parameter int DEPTH = 16
) (
  input logic   clk,
  input logic   rst_n,
  flq_in_if.sink    in_ch,
  flq_out_if.source out_ch
);
  import flq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // node address bits
  localparam int IW = $clog2(DEPTH + 1);                // index bits incl. null
  localparam logic [IW-1:0] NULL_IDX = IW'(DEPTH);

  // node pool memories
  logic [VALUE_W-1:0] value_mem [DEPTH];
  logic [IW-1:0]      next_mem  [DEPTH];

  // control registers
  state_t        state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] fill_r, fill_nxt;     // nodes ever allocated
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  logic               cmd_r;
  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] val_rd_r;
  logic [IW-1:0]      next_rd_r;
  status_t            status_r, status_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;

  // write-back controls
  logic               val_we;
  logic               next_we;
  logic [IW-1:0]      next_wa;
  logic [IW-1:0]      next_wd;

  logic in_fire;
  logic advance;
  logic [IW-1:0] rd_idx;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign advance = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign rd_idx  = (in_ch.cmd == CMD_DEQ) ? head_r : free_head_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_EXEC;
      S_EXEC: if (advance) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // command execution and write-back
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    out_value_nxt = out_value_r;
    occ_nxt       = occ_r;
    val_we        = 1'b0;
    next_we       = 1'b0;
    next_wa       = tail_r;
    next_wd       = free_head_r;

    if (out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_EXEC: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          status_nxt    = ST_OK;
          if (cmd_r == CMD_ENQ) begin
            if (free_head_r >= NULL_IDX) begin
              status_nxt = ST_FULL;
            end else begin
              // fresh nodes chain to the next index
              if (free_head_r >= fill_r) begin
                free_head_nxt = IW'(free_head_r + 1'b1);
                fill_nxt      = IW'(fill_r + 1'b1);
              end else begin
                free_head_nxt = next_rd_r;
              end
              val_we = 1'b1;
              if (head_r >= NULL_IDX) begin
                head_nxt = free_head_r;
              end else begin
                next_we = 1'b1;
                next_wa = tail_r;
                next_wd = free_head_r;
              end
              tail_nxt  = free_head_r;
              count_nxt = IW'(count_r + 1'b1);
            end
          end else begin
            if (head_r >= NULL_IDX) begin
              status_nxt = ST_EMPTY;
            end else begin
              out_value_nxt = val_rd_r;
              // last item leaves: queue goes empty
              if (head_r == tail_r) begin
                head_nxt = NULL_IDX;
                tail_nxt = NULL_IDX;
              end else begin
                head_nxt = next_rd_r;
              end
              next_we       = 1'b1;
              next_wa       = head_r;
              next_wd       = free_head_r;
              free_head_nxt = head_r;
              if (count_r != '0) count_nxt = IW'(count_r - 1'b1);
            end
          end
          occ_nxt = OCC_W'(count_nxt);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_IDX;
      tail_r      <= NULL_IDX;
      free_head_r <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item capture and memory reads on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= in_ch.cmd;
      value_r   <= in_ch.value;
      next_rd_r <= next_mem[rd_idx[AW-1:0]];
      val_rd_r  <= value_mem[head_r[AW-1:0]];
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (val_we) value_mem[free_head_r[AW-1:0]] <= value_r;
    if (next_we) next_mem[next_wa[AW-1:0]] <= next_wd;
  end

  // result register
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    out_value_r <= out_value_nxt;
    occ_r       <= occ_nxt;
  end

  // port drive
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.occupancy = occ_r;

  // queue bookkeeping stays consistent and an accept starts execution
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NULL_IDX) == (count_r == '0))
    else $error("head null and zero count disagree");

  a_tail_head: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r == NULL_IDX) == (head_r == NULL_IDX))
    else $error("tail null and head null disagree");

  a_count_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= fill_r) && (fill_r <= NULL_IDX))
    else $error("occupancy exceeds allocated nodes");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!in_ch.ready && !$stable(state_r)))
    else $error("accept did not start execution");

endmodule
